FILE: src/lss2_pkg.sv
package lss2_pkg;

    // Default number of accumulator bins
    localparam int NUM_BINS_DEF = 1024;

    // Coefficient fraction bits (Q1.30)
    localparam int COEF_FRAC = 30;

    // Width of the bin_number output field
    localparam int BIN_OUT_W = 10;

    // Configuration register indexes
    localparam logic [1:0] CFG_K_DT         = 2'd0;
    localparam logic [1:0] CFG_DT_OVER_ZETA = 2'd1;
    localparam logic [1:0] CFG_BIN_SIZE     = 2'd2;
    localparam logic [1:0] CFG_ITERATIONS   = 2'd3;

    // Configuration reset values
    localparam logic [15:0] BIN_SIZE_RST   = 16'd1;
    localparam logic [26:0] ITERATIONS_RST = 27'd1024;

    // Multiplier operand selections
    localparam logic [1:0] ALU_DN = 2'd0;  // dt_over_zeta * noise
    localparam logic [1:0] ALU_KP = 2'd1;  // k_dt * position
    localparam logic [1:0] ALU_KS = 2'd2;  // k_dt * (position + tmp)
    localparam logic [1:0] ALU_SQ = 2'd3;  // new position squared

    // Control from the sequencer to the shared multiplier
    typedef struct packed {
        logic       en;
        logic [1:0] sel;
    } t_alu_ctrl;

    localparam logic signed [66:0] RND30 = 67'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [66:0] RND31 = 67'sd1 <<< COEF_FRAC;
    localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
    localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

    // Round half up a coefficient product back to position scale.
    // sh31 folds in the extra factor of one half.
    function automatic logic signed [35:0] f_round(input logic signed [65:0] p,
                                                   input logic sh31);
        logic signed [66:0] t;
        logic signed [66:0] s;
        t = $signed({p[65], p}) + (sh31 ? RND31 : RND30);
        s = sh31 ? (t >>> (COEF_FRAC + 1)) : (t >>> COEF_FRAC);
        return s[35:0];
    endfunction

    // Clamp to the signed 32 bit range
    function automatic logic signed [31:0] f_sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/lss2_ram.sv
module lss2_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lss2_alu.sv
module lss2_alu
    import lss2_pkg::*;
(
    input  logic               i_clk,
    input  t_alu_ctrl          i_ctrl,
    input  logic [30:0]        i_k_dt,
    input  logic [30:0]        i_dt_over_zeta,
    input  logic signed [31:0] i_noise,
    input  logic signed [31:0] i_pos,
    input  logic signed [31:0] i_tmp,
    input  logic signed [31:0] i_npos,
    output logic signed [65:0] o_prod
);

    logic signed [32:0] w_a;
    logic signed [32:0] w_b;
    logic signed [32:0] w_pos_tmp;
    logic signed [65:0] r_prod;

    // Sum of position and predictor for the corrector product
    assign w_pos_tmp = $signed({i_pos[31], i_pos}) + $signed({i_tmp[31], i_tmp});

    // Pick operands for this step
    always_comb begin
        case (i_ctrl.sel)
            ALU_DN: begin
                w_a = $signed({2'b00, i_dt_over_zeta});
                w_b = $signed({i_noise[31], i_noise});
            end
            ALU_KP: begin
                w_a = $signed({2'b00, i_k_dt});
                w_b = $signed({i_pos[31], i_pos});
            end
            ALU_KS: begin
                w_a = $signed({2'b00, i_k_dt});
                w_b = w_pos_tmp;
            end
            ALU_SQ: begin
                w_a = $signed({i_npos[31], i_npos});
                w_b = $signed({i_npos[31], i_npos});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_prod <= w_a * w_b;
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: src/langevin_spring_srk2_step.sv
// o_valid rises once a noise request accepted in idle has passed the DN, KP, TMP, KS, NPOS, SQ
// and ACC states (if it has a result); no new request is taken until idle again. One shared 33x33 multiplier
// is used four times per step (noise gain, spring term, corrector term, squared position).
// Reset (synchronous, active low): registers to defaults, bead state to zero, then a
// clearing pass over every accumulator memory address before o_ready rises;
// configuration writes are taken during the pass.
module langevin_spring_srk2_step
    import lss2_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // noise requests
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_noise_sample,
    // results
    output logic               o_valid,
    input  logic               i_ready,
    output logic [9:0]         o_bin_number,
    output logic [63:0]        o_sum_of_squares,
    output logic signed [31:0] o_position,
    output logic               o_end_of_sample
);

    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [BW-1:0] BIN_LAST = BW'(NUM_BINS - 1);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DN   = 4'd2;
    localparam logic [3:0] ST_KP   = 4'd3;
    localparam logic [3:0] ST_TMP  = 4'd4;
    localparam logic [3:0] ST_KS   = 4'd5;
    localparam logic [3:0] ST_NPOS = 4'd6;
    localparam logic [3:0] ST_SQ   = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [30:0]        r_k_dt;
    logic [30:0]        r_dt_over_zeta;
    logic [15:0]        r_bin_size;
    logic [26:0]        r_iterations;
    logic signed [31:0] r_noise;
    logic signed [35:0] r_dn;
    logic signed [31:0] r_tmp;
    logic signed [31:0] r_npos;
    logic signed [31:0] r_pos;
    logic [15:0]        r_step_in_bin;
    logic [BW-1:0]      r_cur_bin;
    logic [25:0]        r_step_in_sample;
    logic               r_rec;
    logic               r_last;
    logic [BW-1:0]      r_clr_addr;
    logic               r_out_valid;
    logic [9:0]         r_out_bin;
    logic [63:0]        r_out_sum;
    logic signed [31:0] r_out_pos;
    logic               r_out_end;

    t_alu_ctrl          w_alu_ctrl;
    logic signed [65:0] w_prod;
    logic signed [35:0] w_rnd;
    logic signed [37:0] w_tmp_sum;
    logic signed [37:0] w_npos_sum;
    logic [15:0]        w_bsz;
    logic [26:0]        w_its;
    logic [16:0]        w_bin_cnt;
    logic [26:0]        w_sample_cnt;
    logic [63:0]        w_rdata;
    logic [64:0]        w_acc_sum;
    logic [63:0]        w_acc_new;
    logic               w_acc_go;
    logic [BW-1:0]      w_next_bin;
    logic [BW+9:0]      w_bin_ext;
    logic               w_we;
    logic [BW-1:0]      w_waddr;
    logic [63:0]        w_wdata;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_dt         <= '0;
            r_dt_over_zeta <= '0;
            r_bin_size     <= BIN_SIZE_RST;
            r_iterations   <= ITERATIONS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_K_DT:         r_k_dt         <= i_cfg_data[30:0];
                CFG_DT_OVER_ZETA: r_dt_over_zeta <= i_cfg_data[30:0];
                CFG_BIN_SIZE:     r_bin_size     <= i_cfg_data[15:0];
                CFG_ITERATIONS:   r_iterations   <= i_cfg_data[26:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier
    always_comb begin
        w_alu_ctrl.en  = 1'b1;
        w_alu_ctrl.sel = ALU_DN;
        case (r_state)
            ST_DN:   w_alu_ctrl.sel = ALU_DN;
            ST_KP:   w_alu_ctrl.sel = ALU_KP;
            ST_KS:   w_alu_ctrl.sel = ALU_KS;
            ST_SQ:   w_alu_ctrl.sel = ALU_SQ;
            default: w_alu_ctrl.en  = 1'b0;
        endcase
    end

    lss2_alu u_alu (
        .i_clk          (i_clk),
        .i_ctrl         (w_alu_ctrl),
        .i_k_dt         (r_k_dt),
        .i_dt_over_zeta (r_dt_over_zeta),
        .i_noise        (r_noise),
        .i_pos          (r_pos),
        .i_tmp          (r_tmp),
        .i_npos         (r_npos),
        .o_prod         (w_prod)
    );

    // Round the held product; the corrector term takes the extra half
    assign w_rnd      = f_round(w_prod, r_state == ST_NPOS);
    assign w_tmp_sum  = 38'(r_pos) - 38'(w_rnd) + 38'(r_dn);
    assign w_npos_sum = 38'(r_pos) - 38'(w_rnd) + 38'(r_dn);

    // Bin and sample boundaries, zero settings act as one
    assign w_bsz        = (r_bin_size == '0) ? 16'd1 : r_bin_size;
    assign w_its        = (r_iterations == '0) ? 27'd1 : r_iterations;
    assign w_bin_cnt    = {1'b0, r_step_in_bin} + 17'd1;
    assign w_sample_cnt = {1'b0, r_step_in_sample} + 27'd1;
    assign w_next_bin   = (r_cur_bin == BIN_LAST) ? '0 : r_cur_bin + 1'b1;

    // Saturating accumulate of the squared position
    assign w_acc_sum = {1'b0, w_rdata} + {1'b0, w_prod[63:0]};
    assign w_acc_new = w_acc_sum[64] ? '1 : w_acc_sum[63:0];
    assign w_acc_go  = (r_state == ST_ACC) && (!r_out_valid || i_ready);
    assign w_bin_ext = {{10{1'b0}}, r_cur_bin};

    // Accumulator memory: clearing pass after reset, update on record
    assign w_we    = (r_state == ST_CLR) || (w_acc_go && r_rec);
    assign w_waddr = (r_state == ST_CLR) ? r_clr_addr : r_cur_bin;
    assign w_wdata = (r_state == ST_CLR) ? 64'd0 : w_acc_new;

    lss2_ram #(
        .WIDTH (64),
        .DEPTH (NUM_BINS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == ST_DN),
        .i_raddr (r_cur_bin),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  if (r_clr_addr == BIN_LAST) n_state = ST_IDLE;
            ST_IDLE: if (i_valid) n_state = ST_DN;
            ST_DN:   n_state = ST_KP;
            ST_KP:   n_state = ST_TMP;
            ST_TMP:  n_state = ST_KS;
            ST_KS:   n_state = ST_NPOS;
            ST_NPOS: n_state = ST_SQ;
            ST_SQ:   n_state = ST_ACC;
            ST_ACC:  if (w_acc_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Step datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_noise <= i_noise_sample;
        end
        if (r_state == ST_KP) begin
            r_dn <= w_rnd;
        end
        if (r_state == ST_TMP) begin
            r_tmp <= f_sat32(w_tmp_sum);
        end
        if (r_state == ST_NPOS) begin
            r_npos <= f_sat32(w_npos_sum);
        end
        if (r_state == ST_SQ) begin
            r_rec  <= (w_bin_cnt >= {1'b0, w_bsz});
            r_last <= (w_sample_cnt >= w_its);
        end
    end

    // Bead and counter state, advance on each finished step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos            <= '0;
            r_step_in_bin    <= '0;
            r_cur_bin        <= '0;
            r_step_in_sample <= '0;
        end else if (w_acc_go) begin
            r_pos            <= r_last ? 32'sd0 : r_npos;
            r_step_in_bin    <= (r_rec || r_last) ? 16'd0 : w_bin_cnt[15:0];
            r_cur_bin        <= r_last ? '0 : (r_rec ? w_next_bin : r_cur_bin);
            r_step_in_sample <= r_last ? 26'd0 : w_sample_cnt[25:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc_go && (r_rec || r_last)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_go && (r_rec || r_last)) begin
            r_out_bin <= r_rec ? w_bin_ext[9:0] : 10'd0;
            r_out_sum <= r_rec ? w_acc_new : 64'd0;
            r_out_pos <= r_npos;
            r_out_end <= r_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bin_number     = r_out_bin;
    assign o_sum_of_squares = r_out_sum;
    assign o_position       = r_out_pos;
    assign o_end_of_sample  = r_out_end;

    // Bin index never leaves the memory range
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_bin <= BIN_LAST)
        else $error("bin index past last bin");

    // No request taken during the clearing pass
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_ready)
        else $error("request accepted while clearing");

    // Sample end returns bead and counters to zero
    a_sample_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_go && r_last) |=>
            (r_pos == 32'sd0 && r_cur_bin == '0 && r_step_in_sample == 26'd0
             && r_step_in_bin == 16'd0))
        else $error("state not cleared at sample end");

    // A finished step with a result always loads a valid result
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_go && (r_rec || r_last)) |=> (o_valid && o_end_of_sample == $past(r_last)))
        else $error("result not loaded");

endmodule

FILE: bench/tb_langevin_spring_srk2_step.sv
`timescale 1ns / 1ps

module tb_langevin_spring_srk2_step;
    import lss2_pkg::*;

    localparam int NUM_BINS     = NUM_BINS_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int QUIET_LIMIT  = 4000;

    typedef enum int {PACE_FREE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

    typedef struct {
        logic signed [31:0] noise;
        bit                 hold;
    } noise_req_t;

    typedef struct packed {
        logic [9:0]  bin;
        logic [63:0] sum;
        logic [31:0] pos;
        logic        eos;
    } bin_record_t;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index    = '0;
    logic [31:0]        i_cfg_data     = '0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_noise_sample = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [9:0]         o_bin_number;
    logic [63:0]        o_sum_of_squares;
    logic signed [31:0] o_position;
    logic               o_end_of_sample;

    // Predicted block state and registers
    logic [30:0]        k_coef;
    logic [30:0]        noise_gain;
    logic [15:0]        bin_len;
    logic [26:0]        sample_len;
    logic signed [31:0] bead_pos;
    int unsigned        bin_steps;
    int unsigned        cur_bin;
    int unsigned        sample_steps;
    logic [63:0]        bin_acc [NUM_BINS];

    noise_req_t  pending_noise[$];
    bin_record_t expected_records[$];
    noise_req_t  next_req;
    bin_record_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued_cnt     = 0;
    int accepted_cnt   = 0;
    int mism_cnt       = 0;
    int quiet_cycles   = 0;
    int ph;

    langevin_spring_srk2_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_noise_sample   (i_noise_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_bin_number     (o_bin_number),
        .o_sum_of_squares (o_sum_of_squares),
        .o_position       (o_position),
        .o_end_of_sample  (o_end_of_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor of (x + half LSB) / 2^s
    function automatic logic signed [79:0] round_half_up(input logic signed [79:0] x,
                                                         input int s);
        logic signed [79:0] r;
        r = x + (80'sd1 <<< (s - 1));
        return r >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -80'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Advance the bead one Heun step and queue the bin record it produces
    task automatic advance_bead(input logic signed [31:0] noise);
        logic signed [79:0] n80, k80, d80, p80, dn, tmp, half;
        logic signed [31:0] npos;
        logic signed [63:0] p64;
        logic [63:0]        sq;
        logic [64:0]        tot;
        int unsigned        bsz, its, idx;
        bit                 rec, last;
        bin_record_t        r;
        n80 = noise;
        k80 = $signed({49'd0, k_coef});
        d80 = $signed({49'd0, noise_gain});
        p80 = bead_pos;
        dn = round_half_up(d80 * n80, COEF_FRAC);
        tmp = clamp32(p80 - round_half_up(k80 * p80, COEF_FRAC) + dn);
        half = round_half_up(k80 * (p80 + tmp), COEF_FRAC + 1);
        npos = clamp32(p80 - half + dn);
        bead_pos = npos;
        bsz = (bin_len == 0) ? 1 : bin_len;
        its = (sample_len == 0) ? 1 : sample_len;
        rec = 1'b0;
        r = '0;
        bin_steps++;
        if (bin_steps >= bsz) begin
            p64 = npos;
            sq = p64 * p64;
            idx = cur_bin % NUM_BINS;
            tot = {1'b0, bin_acc[idx]} + {1'b0, sq};
            bin_acc[idx] = tot[64] ? '1 : tot[63:0];
            rec = 1'b1;
            r.bin = idx[9:0];
            r.sum = bin_acc[idx];
            bin_steps = 0;
            cur_bin = (idx + 1) % NUM_BINS;
        end
        sample_steps++;
        last = (sample_steps >= its);
        if (last) begin
            bead_pos = '0;
            bin_steps = 0;
            cur_bin = 0;
            sample_steps = 0;
        end
        if (rec || last) begin
            r.pos = npos;
            r.eos = last;
            expected_records.insert(expected_records.size(), r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t: %s mismatch, got %h, want %h", $time, what, got, exp_val);
        mism_cnt++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_K_DT:         k_coef     = data[30:0];
            CFG_DT_OVER_ZETA: noise_gain = data[30:0];
            CFG_BIN_SIZE:     bin_len    = data[15:0];
            CFG_ITERATIONS:   sample_len = data[26:0];
            default: ;
        endcase
    endtask

    // Write all four registers; unused upper data bits carry noise
    task automatic write_all(input logic [30:0] k, input logic [30:0] d,
                             input logic [15:0] bsz, input logic [26:0] its);
        logic [31:0] r;
        r = $urandom;
        write_reg(CFG_K_DT, {r[31], k});
        write_reg(CFG_DT_OVER_ZETA, {r[30], d});
        write_reg(CFG_BIN_SIZE, {r[15:0], bsz});
        write_reg(CFG_ITERATIONS, {r[27:23], its});
    endtask

    task automatic set_pace(input pace_t p);
        case (p)
            PACE_FREE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            PACE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default:   begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    task automatic push_noise(input logic signed [31:0] n, input bit hold);
        noise_req_t q;
        q.noise = n;
        q.hold = hold;
        pending_noise.insert(pending_noise.size(), q);
        queued_cnt++;
    endtask

    // Wait until every request is taken and every record is back, then let the pipe empty
    task automatic settle();
        while (accepted_cnt != queued_cnt || expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [30:0] pick_coef(input bit is_gain);
        case ($urandom_range(3))
            0: return '0;
            1: return 31'h7FFFFFFF;
            2: return is_gain ? 31'($urandom_range(32'h0100_0000, 32'h4000_0000))
                              : 31'($urandom_range(0, 32'h1000_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_bin_size();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return 16'($urandom_range(5, 12));
        return 16'($urandom_range(1, 4));
    endfunction

    function automatic logic [26:0] pick_iterations();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return 27'($urandom_range(100, 400));
        return 27'($urandom_range(1, 40));
    endfunction

    function automatic logic signed [31:0] rand_noise();
        if ($urandom_range(3) == 0) return $urandom;
        return int'($urandom_range(0, 2097152)) - 1048576;
    endfunction

    // Drive noise requests; hold each until taken, optionally wait for an empty pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                advance_bead(i_noise_sample);
                accepted_cnt++;
            end
            if (!i_valid || o_ready) begin
                if (pending_noise.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(pending_noise[0].hold && expected_records.size() != 0)) begin
                    next_req = pending_noise.pop_front();
                    i_noise_sample <= next_req.noise;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Take bin records and compare against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("unrequested record, position", o_position, '0);
                end else begin
                    want = expected_records.pop_front();
                    if (o_bin_number !== want.bin)
                        report_mismatch("bin_number", o_bin_number, want.bin);
                    if (o_sum_of_squares !== want.sum)
                        report_mismatch("sum_of_squares", o_sum_of_squares, want.sum);
                    if (o_position !== want.pos)
                        report_mismatch("position", o_position, want.pos);
                    if (o_end_of_sample !== want.eos)
                        report_mismatch("end_of_sample", o_end_of_sample, want.eos);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if no channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[langevin_spring_srk2_step] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        k_coef = '0;
        noise_gain = '0;
        bin_len = BIN_SIZE_RST;
        sample_len = ITERATIONS_RST;
        bead_pos = '0;
        bin_steps = 0;
        cur_bin = 0;
        sample_steps = 0;
        for (int i = 0; i < NUM_BINS; i++) bin_acc[i] = '0;
        set_pace(PACE_FREE);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: zero gains keep the bead at rest
        push_noise(32'sh7FFFFFFF, 1'b0);
        push_noise(32'sh80000000, 1'b0);
        settle();

        // Full noise gain, no spring: saturate position and the bin 0 sum
        write_all('0, 31'h7FFFFFFF, 16'd1, 27'd1);
        repeat (5) push_noise(32'sh7FFFFFFF, 1'b0);
        push_noise(32'sh80000000, 1'b0);
        settle();

        // Strongest spring and gain over a short sample
        write_all(31'h7FFFFFFF, 31'h7FFFFFFF, 16'd1, 27'd4);
        push_noise(32'sh7FFFFFFF, 1'b0);
        push_noise(32'sh80000000, 1'b0);
        push_noise(32'sd0, 1'b0);
        push_noise(-32'sd1, 1'b0);
        push_noise(32'sd1, 1'b0);
        push_noise(32'sh7FFFFFFF, 1'b0);
        settle();

        // Zero bin size and zero iterations act as one
        write_all(31'h0400_0000, 31'h4000_0000, 16'd0, 27'd0);
        push_noise(32'sd65536, 1'b0);
        push_noise(-32'sd65536, 1'b0);
        push_noise(32'sd3, 1'b0);
        settle();

        // Sample end that falls between bin boundaries
        write_all(31'h0800_0000, 31'h2000_0000, 16'd3, 27'd5);
        repeat (7) push_noise(rand_noise(), 1'b0);
        settle();

        // Largest bin size and iteration count: no records
        write_all(31'h0010_0000, 31'h0100_0000, 16'hFFFF, 27'h7FF_FFFF);
        push_noise(32'sd1000, 1'b0);
        push_noise(-32'sd1000, 1'b0);
        settle();

        // Random phases over all pacing modes
        for (ph = 0; ph < 8; ph++) begin
            write_all(pick_coef(1'b0), pick_coef(1'b1), pick_bin_size(), pick_iterations());
            set_pace(pace_t'(ph % 4));
            repeat (80) push_noise(rand_noise(), $urandom_range(19) == 0);
            settle();
        end

        if (mism_cnt == 0) begin
            $display("[langevin_spring_srk2_step] OK");
        end else begin
            $display("[langevin_spring_srk2_step] ERROR");
        end
        $finish;
    end

endmodule
